// ----- hw/rtl/dwkrl_pkg.sv -----
// ----------------------------------------------------------------------------
// dwkrl_pkg
// Shared constants, types and helpers of the dual-window keyed rate limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package dwkrl_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

  localparam int TIME_W = 40;
  localparam int ID_W = 32;
  localparam int CNT_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0] MINUTE_SECONDS = 16'd60;

  localparam logic [CFG_DATA_W-1:0] RST_BURST_SECONDS = 16'd10;
  localparam logic [CFG_DATA_W-1:0] RST_GLOBAL_BURST_LIMIT = 16'd100;
  localparam logic [CFG_DATA_W-1:0] RST_GLOBAL_MINUTE_LIMIT = 16'd600;
  localparam logic [CFG_DATA_W-1:0] RST_KEY_BURST_LIMIT = 16'd5;
  localparam logic [CFG_DATA_W-1:0] RST_KEY_MINUTE_LIMIT = 16'd30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BURST_SECONDS       = 3'd0,
    REG_GLOBAL_BURST_LIMIT  = 3'd1,
    REG_GLOBAL_MINUTE_LIMIT = 3'd2,
    REG_KEY_BURST_LIMIT     = 3'd3,
    REG_KEY_MINUTE_LIMIT    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GWIN,
    ST_GCHK,
    ST_SCAN,
    ST_WAIT,
    ST_SEL,
    ST_KCHK
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   conversation;
    logic [ID_W-1:0]   actor;
    logic [TIME_W-1:0] burst_start;
    logic [TIME_W-1:0] minute_start;
    logic [CNT_W-1:0]  burst_cnt;
    logic [CNT_W-1:0]  minute_cnt;
  } row_t;

  typedef struct packed {
    logic              load;
    logic              gwin;
    logic              scan_clear;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              sel;
    logic              commit;
    logic              reject;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic global_full;
    logic hit_now;
  } status_t;

  // A window is over when time went backwards or its length has elapsed.
  function automatic logic window_over(input logic [TIME_W-1:0] now,
                                       input logic [TIME_W-1:0] start,
                                       input logic [CNT_W-1:0] len);
    logic signed [TIME_W:0] diff;
    diff = $signed({now[TIME_W-1], now}) - $signed({start[TIME_W-1], start});
    return diff[TIME_W] || (diff >= $signed({{(TIME_W + 1 - CNT_W){1'b0}}, len}));
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dwkrl_ctrl.sv -----
// ----------------------------------------------------------------------------
// dwkrl_ctrl
// Sequencer: global window step, global check, table scan, slot update.
// ----------------------------------------------------------------------------
`default_nettype none

module dwkrl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  dwkrl_pkg::status_t  status,
  output dwkrl_pkg::cmd_t     cmd,
  output logic                busy
);

  dwkrl_pkg::state_t state, state_next;
  logic [dwkrl_pkg::SLOT_W-1:0] scan_cnt, scan_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dwkrl_pkg::ST_IDLE;
      scan_cnt <= '0;
    end else begin
      state <= state_next;
      scan_cnt <= scan_cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    scan_cnt_next = scan_cnt;
    cmd = '0;
    unique case (state)
      dwkrl_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = dwkrl_pkg::ST_GWIN;
        end
      end
      dwkrl_pkg::ST_GWIN: begin
        if (status.bad) begin
          cmd.reject = 1'b1;
          state_next = dwkrl_pkg::ST_IDLE;
        end else begin
          cmd.gwin = 1'b1;
          state_next = dwkrl_pkg::ST_GCHK;
        end
      end
      dwkrl_pkg::ST_GCHK: begin
        if (status.global_full) begin
          cmd.reject = 1'b1;
          state_next = dwkrl_pkg::ST_IDLE;
        end else begin
          cmd.scan_clear = 1'b1;
          scan_cnt_next = '0;
          state_next = dwkrl_pkg::ST_SCAN;
        end
      end
      dwkrl_pkg::ST_SCAN: begin
        // Reads are issued one slot a cycle; a hit stops the scan early.
        if (status.hit_now) begin
          state_next = dwkrl_pkg::ST_SEL;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_addr = scan_cnt;
          if (scan_cnt == dwkrl_pkg::SLOT_LAST) begin
            state_next = dwkrl_pkg::ST_WAIT;
          end else begin
            scan_cnt_next = scan_cnt + dwkrl_pkg::SLOT_W'(1);
          end
        end
      end
      dwkrl_pkg::ST_WAIT: begin
        state_next = dwkrl_pkg::ST_SEL;
      end
      dwkrl_pkg::ST_SEL: begin
        cmd.sel = 1'b1;
        state_next = dwkrl_pkg::ST_KCHK;
      end
      dwkrl_pkg::ST_KCHK: begin
        cmd.commit = 1'b1;
        state_next = dwkrl_pkg::ST_IDLE;
      end
      default: begin
        state_next = dwkrl_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != dwkrl_pkg::ST_IDLE);

endmodule

`default_nettype wire

// ----- hw/rtl/dwkrl_datapath.sv -----
// ----------------------------------------------------------------------------
// dwkrl_datapath
// Configuration registers, global windows, slot table and scan bookkeeping.
// ----------------------------------------------------------------------------
`default_nettype none

module dwkrl_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [dwkrl_pkg::ID_W-1:0]            conversation_id,
  input  logic [dwkrl_pkg::ID_W-1:0]            actor_id,
  input  logic signed [dwkrl_pkg::TIME_W-1:0]   now_seconds,
  input  logic                                  cfg_write,
  input  logic [dwkrl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dwkrl_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  dwkrl_pkg::cmd_t                       cmd,
  output dwkrl_pkg::status_t                    status,
  output logic                                  done,
  output logic                                  verdict
);

  logic [dwkrl_pkg::CNT_W-1:0] burst_seconds;
  logic [dwkrl_pkg::CNT_W-1:0] global_burst_limit;
  logic [dwkrl_pkg::CNT_W-1:0] global_minute_limit;
  logic [dwkrl_pkg::CNT_W-1:0] key_burst_limit;
  logic [dwkrl_pkg::CNT_W-1:0] key_minute_limit;

  logic [dwkrl_pkg::ID_W-1:0]   conv;
  logic [dwkrl_pkg::ID_W-1:0]   actor;
  logic [dwkrl_pkg::TIME_W-1:0] now;

  logic [dwkrl_pkg::TIME_W-1:0] all_burst_start;
  logic [dwkrl_pkg::CNT_W-1:0]  all_burst_cnt;
  logic [dwkrl_pkg::TIME_W-1:0] all_minute_start;
  logic [dwkrl_pkg::CNT_W-1:0]  all_minute_cnt;

  dwkrl_pkg::row_t mem [dwkrl_pkg::NUM_SLOTS];
  logic [dwkrl_pkg::NUM_SLOTS-1:0] used;

  dwkrl_pkg::row_t              rd_data;
  logic                         rd_valid;
  logic [dwkrl_pkg::SLOT_W-1:0] rd_idx;

  logic                         hit_found;
  logic [dwkrl_pkg::SLOT_W-1:0] hit_idx;
  dwkrl_pkg::row_t              hit_row;
  logic                         free_found;
  logic [dwkrl_pkg::SLOT_W-1:0] free_idx;
  logic                         oldest_found;
  logic [dwkrl_pkg::SLOT_W-1:0] oldest_idx;
  logic [dwkrl_pkg::TIME_W-1:0] oldest_start;

  logic [dwkrl_pkg::SLOT_W-1:0] upd_slot;
  dwkrl_pkg::row_t              upd_row;

  logic rd_used;
  logic rd_match;
  logic hit_burst_over;
  logic hit_minute_over;
  logic key_full;

  // Configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_seconds <= dwkrl_pkg::RST_BURST_SECONDS;
      global_burst_limit <= dwkrl_pkg::RST_GLOBAL_BURST_LIMIT;
      global_minute_limit <= dwkrl_pkg::RST_GLOBAL_MINUTE_LIMIT;
      key_burst_limit <= dwkrl_pkg::RST_KEY_BURST_LIMIT;
      key_minute_limit <= dwkrl_pkg::RST_KEY_MINUTE_LIMIT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dwkrl_pkg::REG_BURST_SECONDS:       burst_seconds <= cfg_data;
        dwkrl_pkg::REG_GLOBAL_BURST_LIMIT:  global_burst_limit <= cfg_data;
        dwkrl_pkg::REG_GLOBAL_MINUTE_LIMIT: global_minute_limit <= cfg_data;
        dwkrl_pkg::REG_KEY_BURST_LIMIT:     key_burst_limit <= cfg_data;
        dwkrl_pkg::REG_KEY_MINUTE_LIMIT:    key_minute_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Request word capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      conv <= conversation_id;
      actor <= actor_id;
      now <= now_seconds;
    end
  end

  assign status.bad = now[dwkrl_pkg::TIME_W-1] || (conv == '0) || (actor == '0);
  assign status.global_full = (all_burst_cnt >= global_burst_limit) ||
                              (all_minute_cnt >= global_minute_limit);

  // Global windows restart before the global check, even if it then rejects.
  always_ff @(posedge clk) begin
    if (rst) begin
      all_burst_start <= '0;
      all_burst_cnt <= '0;
      all_minute_start <= '0;
      all_minute_cnt <= '0;
    end else if (cmd.gwin) begin
      if (dwkrl_pkg::window_over(now, all_burst_start, burst_seconds)) begin
        all_burst_start <= now;
        all_burst_cnt <= '0;
      end
      if (dwkrl_pkg::window_over(now, all_minute_start, dwkrl_pkg::MINUTE_SECONDS)) begin
        all_minute_start <= now;
        all_minute_cnt <= '0;
      end
    end else if (cmd.commit && !key_full) begin
      all_burst_cnt <= all_burst_cnt + dwkrl_pkg::CNT_W'(1);
      all_minute_cnt <= all_minute_cnt + dwkrl_pkg::CNT_W'(1);
    end
  end

  // Slot table: one registered read port for the scan, one write port.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr];
    end
    if (cmd.commit) begin
      if (key_full) begin
        mem[upd_slot] <= upd_row;
      end else begin
        mem[upd_slot] <= '{conversation: upd_row.conversation,
                           actor:        upd_row.actor,
                           burst_start:  upd_row.burst_start,
                           minute_start: upd_row.minute_start,
                           burst_cnt:    upd_row.burst_cnt + dwkrl_pkg::CNT_W'(1),
                           minute_cnt:   upd_row.minute_cnt + dwkrl_pkg::CNT_W'(1)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_en;
      if (cmd.commit) begin
        used[upd_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_idx <= cmd.rd_addr;
    end
  end

  assign rd_used = used[rd_idx];
  assign rd_match = (rd_data.conversation == conv) && (rd_data.actor == actor);
  assign status.hit_now = rd_valid && rd_used && rd_match;

  // Scan bookkeeping: first free slot, hit, and oldest minute window.
  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      hit_found <= 1'b0;
      free_found <= 1'b0;
      oldest_found <= 1'b0;
    end else if (rd_valid) begin
      if (!rd_used) begin
        if (!free_found) begin
          free_found <= 1'b1;
          free_idx <= rd_idx;
        end
      end else if (rd_match) begin
        hit_found <= 1'b1;
        hit_idx <= rd_idx;
        hit_row <= rd_data;
      end else if (!oldest_found ||
                   ($signed(rd_data.minute_start) < $signed(oldest_start))) begin
        oldest_found <= 1'b1;
        oldest_idx <= rd_idx;
        oldest_start <= rd_data.minute_start;
      end
    end
  end

  assign hit_burst_over = dwkrl_pkg::window_over(now, hit_row.burst_start, burst_seconds);
  assign hit_minute_over = dwkrl_pkg::window_over(now, hit_row.minute_start,
                                                  dwkrl_pkg::MINUTE_SECONDS);

  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      if (hit_found) begin
        upd_slot <= hit_idx;
        upd_row.conversation <= hit_row.conversation;
        upd_row.actor <= hit_row.actor;
        upd_row.burst_start <= hit_burst_over ? now : hit_row.burst_start;
        upd_row.burst_cnt <= hit_burst_over ? '0 : hit_row.burst_cnt;
        upd_row.minute_start <= hit_minute_over ? now : hit_row.minute_start;
        upd_row.minute_cnt <= hit_minute_over ? '0 : hit_row.minute_cnt;
      end else begin
        priority if (free_found) begin
          upd_slot <= free_idx;
        end else if (oldest_found) begin
          upd_slot <= oldest_idx;
        end else begin
          upd_slot <= '0;
        end
        upd_row <= '{conversation: conv, actor: actor, burst_start: now,
                     minute_start: now, burst_cnt: '0, minute_cnt: '0};
      end
    end
  end

  assign key_full = (upd_row.burst_cnt >= key_burst_limit) ||
                    (upd_row.minute_cnt >= key_minute_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.reject || cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reject || cmd.commit) begin
      verdict <= cmd.reject || key_full;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dual_window_keyed_rate_limiter_top.sv -----
// ----------------------------------------------------------------------------
// dual_window_keyed_rate_limiter_top
// Per-key and global fixed-window request limiter with a 64-slot key table.
//
// Channel   Signals                                        Direction  Handshake
// request   start, conversation_id, actor_id, now_seconds  in         start & !busy
// result    done, verdict                                  out        done strobe
// config    cfg_write, cfg_index, cfg_data                 in         cfg_write
//
// When the key is not found, a good request reads the whole table in the scan,
// one slot a cycle; a hit ends the scan early. A bad request (negative time or
// a zero id) and a request stopped by a global limit are rejected before the
// scan.
// The result word is shown for one cycle; a new request may start then.
// Reset clears the global windows and the slot valid bits and restores the
// configuration defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_window_keyed_rate_limiter_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [dwkrl_pkg::ID_W-1:0]            conversation_id,
  input  logic [dwkrl_pkg::ID_W-1:0]            actor_id,
  input  logic signed [dwkrl_pkg::TIME_W-1:0]   now_seconds,
  output logic                                  done,
  output logic                                  verdict,
  input  logic                                  cfg_write,
  input  logic [dwkrl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dwkrl_pkg::CFG_DATA_W-1:0]      cfg_data
);

  dwkrl_pkg::cmd_t    cmd;
  dwkrl_pkg::status_t status;

  dwkrl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  dwkrl_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .conversation_id (conversation_id),
    .actor_id        (actor_id),
    .now_seconds     (now_seconds),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .status          (status),
    .done            (done),
    .verdict         (verdict)
  );

  // Every accepted word keeps the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  // A result word appears exactly when the block goes idle.
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("block went idle without a result word");

  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result word without a request in progress");

endmodule

`default_nettype wire
